// File: hdl/utpps_pkg.sv
package utpps_pkg;

	typedef logic signed [31:0] q_t;

	// Latency of the pipelined divider and of the pipelined square root
	localparam int DIV_LAT   = 32;
	localparam int SQRT_LAT  = 32;
	// Back end: divide, y row, divide/sqrt, middle root, divide, root terms, divide
	localparam int BACK_LAT  = 3 * DIV_LAT + SQRT_LAT + 3;

	localparam logic signed [64:0] QMAX = 65'sd2147483647;
	localparam q_t QMAX32 = 32'sh7fffffff;

	typedef struct packed {
		q_t   up;
		q_t   vp;
		q_t   ap;
		q_t   cp;
		q_t   rb0;
		q_t   rb1;
		q_t   rc0;
		q_t   rc1;
		q_t   wp;
		q_t   d;
		q_t   nt0;
		q_t   nt1;
		q_t   ns0;
		q_t   ns1;
		logic bad;
	} mid_t;

	typedef struct packed {
		q_t cs;
		q_t sn;
		q_t tx;
		q_t ty;
		q_t tz;
	} pose_t;

	// ok=1: two poses, ok=0: one result with no pose
	typedef struct packed {
		logic  ok;
		pose_t r0;
		pose_t r1;
	} res_t;

	function automatic q_t sat65(input logic signed [64:0] v);
		if (v > QMAX)
			return QMAX32;
		else if (v < -QMAX)
			return -QMAX32;
		else
			return v[31:0];
	endfunction

	function automatic q_t sin32(input q_t x);
		return (x == 32'sh80000000) ? -QMAX32 : x;
	endfunction

	function automatic q_t qabs(input q_t x);
		return x[31] ? -x : x;
	endfunction

	function automatic logic signed [63:0] sx64(input q_t v);
		return {{32{v[31]}}, v};
	endfunction

	// a*b + c*d exact, round half up, saturate
	function automatic q_t dotr(input q_t a, input q_t b, input q_t c, input q_t d,
			input int fb);
		logic signed [64:0] ea, eb, ec, ed, p;
		ea = a;
		eb = b;
		ec = c;
		ed = d;
		p = ea * eb + ec * ed;
		p = p + (65'sd1 <<< (fb - 1));
		return sat65(p >>> fb);
	endfunction

	function automatic q_t twice(input q_t m, input logic neg);
		logic signed [64:0] e;
		e = m;
		e = e <<< 1;
		if (neg)
			e = -e;
		return sat65(e);
	endfunction

endpackage

// File: hdl/utpps_fifo.sv
module utpps_fifo import utpps_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0] mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: hdl/utpps_div.sv
// Signed quotient (num/den) truncated toward zero, saturated to Q range.
// One quotient bit per stage after the first, which checks for overflow.
module utpps_div import utpps_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] num,
	input  logic signed [63:0] den,
	output q_t                 quo
);

	localparam int QB = DIV_LAT - 1;

	logic [63:0] rem_q [DIV_LAT];
	logic [63:0] nm_q  [DIV_LAT];
	logic [63:0] dm_q  [DIV_LAT];
	logic [QB-1:0] qb_q [DIV_LAT];
	logic neg_q [DIV_LAT];
	logic ovf_q [DIV_LAT];
	logic [63:0] nmag, dmag;
	q_t mag;

	assign nmag = num[63] ? (~num + 64'd1) : num;
	assign dmag = den[63] ? (~den + 64'd1) : den;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= nmag >> QB;
			nm_q[0]  <= nmag;
			dm_q[0]  <= dmag;
			qb_q[0]  <= '0;
			neg_q[0] <= num[63] ^ den[63];
			// quotient of 2^31 or more saturates
			ovf_q[0] <= ((nmag >> QB) >= dmag);
		end
	end

	for (genvar s = 1; s < DIV_LAT; s++) begin : g_st
		localparam logic [QB-1:0] QBIT = {{(QB-1){1'b0}}, 1'b1} << (QB - s);
		logic [64:0] tr;
		logic ge;
		assign tr = {rem_q[s-1], nm_q[s-1][QB-s]};
		assign ge = (tr >= {1'b0, dm_q[s-1]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[s] <= ge ? 64'(tr - {1'b0, dm_q[s-1]}) : tr[63:0];
				qb_q[s]  <= ge ? (qb_q[s-1] | QBIT) : qb_q[s-1];
				nm_q[s]  <= nm_q[s-1];
				dm_q[s]  <= dm_q[s-1];
				neg_q[s] <= neg_q[s-1];
				ovf_q[s] <= ovf_q[s-1];
			end
		end
	end

	assign mag = ovf_q[DIV_LAT-1] ? QMAX32 : {1'b0, qb_q[DIV_LAT-1]};
	assign quo = neg_q[DIV_LAT-1] ? -mag : mag;

endmodule

// File: hdl/utpps_isqrt.sv
// Floor square root of a 64-bit value, two radicand bits per stage.
module utpps_isqrt import utpps_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] din,
	output logic [32:0] root
);

	logic [63:0] n_q [SQRT_LAT];
	logic [63:0] r_q [SQRT_LAT];

	for (genvar j = 0; j < SQRT_LAT; j++) begin : g_st
		localparam logic [63:0] BT = 64'd1 << (62 - 2 * j);
		logic [63:0] ni, ri, tr;
		if (j == 0) begin : g_first
			assign ni = din;
			assign ri = '0;
		end else begin : g_next
			assign ni = n_q[j-1];
			assign ri = r_q[j-1];
		end
		assign tr = ri + BT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (ni >= tr) begin
					n_q[j] <= ni - tr;
					r_q[j] <= (ri >> 1) + BT;
				end else begin
					n_q[j] <= ni;
					r_q[j] <= ri >> 1;
				end
			end
		end
	end

	assign root = r_q[SQRT_LAT-1][32:0];

endmodule

// File: hdl/utpps_front.sv
// Builds the reduced 2x2 system and flags singular problems.
module utpps_front import utpps_pkg::*; #(
	parameter int FRAC_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  q_t   bearing0_x,
	input  q_t   bearing0_y,
	input  q_t   bearing0_w,
	input  q_t   bearing1_x,
	input  q_t   bearing1_y,
	input  q_t   bearing1_w,
	input  q_t   point0_x,
	input  q_t   point0_y,
	input  q_t   point0_z,
	input  q_t   point1_x,
	input  q_t   point1_y,
	input  q_t   point1_z,
	output logic out_valid,
	input  logic out_ready,
	output mid_t out_item
);

	logic [2:0] vld_q;
	logic en;
	q_t iu[2], iv[2], iw[2], ix[2], iy[2], iz[2];

	q_t u_s1[2], v_s1[2], w_s1[2], a_s1[2], c_s1[2];
	q_t rb_s1[2][2], rc_s1[2][2];
	q_t pp_s1, rr_s1;

	q_t qm_s2, ss_s2, pp_s2, rr_s2;
	q_t h_s2[2], j_s2[2];
	q_t up_s2, vp_s2, ap_s2, cp_s2, wp_s2;
	q_t rbp_s2[2], rcp_s2[2];
	logic psel;

	q_t dval;
	mid_t item_s3;

	assign en        = !vld_q[2] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[2];
	assign out_item  = item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[1:0], in_valid};
	end

	always_comb begin
		iu[0] = sin32(bearing0_x);
		iv[0] = sin32(bearing0_y);
		iw[0] = sin32(bearing0_w);
		iu[1] = sin32(bearing1_x);
		iv[1] = sin32(bearing1_y);
		iw[1] = sin32(bearing1_w);
		ix[0] = sin32(point0_x);
		iy[0] = sin32(point0_y);
		iz[0] = sin32(point0_z);
		ix[1] = sin32(point1_x);
		iy[1] = sin32(point1_y);
		iz[1] = sin32(point1_z);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				u_s1[i]     <= iu[i];
				v_s1[i]     <= iv[i];
				w_s1[i]     <= iw[i];
				a_s1[i]     <= dotr(ix[i], iw[i], iz[i], iu[i], FRAC_BITS);
				c_s1[i]     <= dotr(iy[i], iw[i], iz[i], iv[i], FRAC_BITS);
				rb_s1[i][0] <= twice(dotr(iy[i], iw[i], '0, '0, FRAC_BITS), 1'b1);
				rb_s1[i][1] <= dotr(ix[i], iw[i], iz[i], -iu[i], FRAC_BITS);
				rc_s1[i][0] <= twice(dotr(ix[i], iw[i], '0, '0, FRAC_BITS), 1'b0);
				rc_s1[i][1] <= dotr(iy[i], iw[i], iz[i], -iv[i], FRAC_BITS);
			end
			pp_s1 <= dotr(iu[0], iw[1], iu[1], -iw[0], FRAC_BITS);
			rr_s1 <= dotr(iv[0], iw[1], iv[1], -iw[0], FRAC_BITS);
		end
	end

	// back substitution row: larger |w|, first row on a tie
	assign psel = (qabs(w_s1[1]) > qabs(w_s1[0]));

	always_ff @(posedge clk) begin
		if (en) begin
			qm_s2 <= dotr(a_s1[0], w_s1[1], a_s1[1], -w_s1[0], FRAC_BITS);
			ss_s2 <= dotr(c_s1[0], w_s1[1], c_s1[1], -w_s1[0], FRAC_BITS);
			for (int k = 0; k < 2; k++) begin
				h_s2[k]   <= dotr(rb_s1[0][k], w_s1[1], rb_s1[1][k], -w_s1[0], FRAC_BITS);
				j_s2[k]   <= dotr(rc_s1[0][k], w_s1[1], rc_s1[1][k], -w_s1[0], FRAC_BITS);
				rbp_s2[k] <= psel ? rb_s1[1][k] : rb_s1[0][k];
				rcp_s2[k] <= psel ? rc_s1[1][k] : rc_s1[0][k];
			end
			pp_s2 <= pp_s1;
			rr_s2 <= rr_s1;
			up_s2 <= psel ? u_s1[1] : u_s1[0];
			vp_s2 <= psel ? v_s1[1] : v_s1[0];
			ap_s2 <= psel ? a_s1[1] : a_s1[0];
			cp_s2 <= psel ? c_s1[1] : c_s1[0];
			wp_s2 <= psel ? w_s1[1] : w_s1[0];
		end
	end

	assign dval = dotr(pp_s2, ss_s2, qm_s2, -rr_s2, FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			item_s3.up  <= up_s2;
			item_s3.vp  <= vp_s2;
			item_s3.ap  <= ap_s2;
			item_s3.cp  <= cp_s2;
			item_s3.rb0 <= rbp_s2[0];
			item_s3.rb1 <= rbp_s2[1];
			item_s3.rc0 <= rcp_s2[0];
			item_s3.rc1 <= rcp_s2[1];
			item_s3.wp  <= wp_s2;
			item_s3.d   <= dval;
			item_s3.nt0 <= dotr(h_s2[0], ss_s2, j_s2[0], -qm_s2, FRAC_BITS);
			item_s3.nt1 <= dotr(h_s2[1], ss_s2, j_s2[1], -qm_s2, FRAC_BITS);
			item_s3.ns0 <= dotr(pp_s2, j_s2[0], rr_s2, -h_s2[0], FRAC_BITS);
			item_s3.ns1 <= dotr(pp_s2, j_s2[1], rr_s2, -h_s2[1], FRAC_BITS);
			item_s3.bad <= (dval == '0) || (wp_s2 == '0);
		end
	end

endmodule

// File: hdl/utpps_back.sv
// Solves the reduced system, the quadratic, and the pose for each root.
module utpps_back import utpps_pkg::*; #(
	parameter int FRAC_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  mid_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_item
);

	typedef struct packed {
		q_t   up;
		q_t   vp;
		q_t   ap;
		q_t   cp;
		q_t   rb0;
		q_t   rb1;
		q_t   rc0;
		q_t   rc1;
		q_t   wp;
		logic bad;
	} a_t;

	typedef struct packed {
		q_t   t20;
		q_t   t21;
		q_t   c2;
		q_t   c3;
		logic fail;
	} c_t;

	typedef struct packed {
		q_t                 y00;
		q_t                 y01;
		q_t                 y02;
		q_t                 y10;
		q_t                 y11;
		q_t                 y12;
		logic signed [33:0] m;
		logic               mz;
		logic               fail;
	} e_t;

	logic [BACK_LAT-1:0] vld_q;
	logic en;

	// divide by D
	logic signed [63:0] a_num[4];
	q_t a_quo[4];
	a_t a_s1[DIV_LAT];

	// y rows and discriminant
	q_t yn_s2[4];
	q_t t2_s2[2];
	q_t c2_s2, c3_s2, wp_s2;
	logic [63:0] disc_s2;
	logic fail_s2;
	q_t b_s0, b_s1, b_c2, b_c3;
	logic [63:0] c2sq, four;

	// divide by w, square root
	q_t c_quo[4];
	logic [32:0] sq;
	c_t c_s3[DIV_LAT];

	// middle root
	e_t e_s4;
	logic signed [34:0] ec2, esq, sm, smj;

	// first root
	q_t c3_s4;
	logic signed [63:0] e_num;
	q_t e_quo;
	e_t e_s5[DIV_LAT];

	// per-root terms
	logic signed [63:0] num_s6[2][5];
	logic signed [63:0] den_s6[2];
	logic fail_s6;
	q_t rq[2];
	q_t yr[2][3];
	logic signed [64:0] mext;

	// final divides
	q_t g_quo[2][5];
	logic g_s7[DIV_LAT];

	assign en        = !vld_q[BACK_LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[BACK_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[BACK_LAT-2:0], in_valid};
	end

	assign a_num[0] = sx64(in_item.nt0) <<< FRAC_BITS;
	assign a_num[1] = sx64(in_item.nt1) <<< FRAC_BITS;
	assign a_num[2] = sx64(in_item.ns0) <<< FRAC_BITS;
	assign a_num[3] = sx64(in_item.ns1) <<< FRAC_BITS;

	for (genvar i = 0; i < 4; i++) begin : g_da
		utpps_div u_div (
			.clk (clk),
			.en  (en),
			.num (a_num[i]),
			.den (sx64(in_item.d)),
			.quo (a_quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0].up  <= in_item.up;
			a_s1[0].vp  <= in_item.vp;
			a_s1[0].ap  <= in_item.ap;
			a_s1[0].cp  <= in_item.cp;
			a_s1[0].rb0 <= in_item.rb0;
			a_s1[0].rb1 <= in_item.rb1;
			a_s1[0].rc0 <= in_item.rc0;
			a_s1[0].rc1 <= in_item.rc1;
			a_s1[0].wp  <= in_item.wp;
			a_s1[0].bad <= in_item.bad;
			for (int i = 1; i < DIV_LAT; i++)
				a_s1[i] <= a_s1[i-1];
		end
	end

	always_comb begin
		b_s0 = a_quo[2];
		b_s1 = a_quo[3];
		b_c2 = -b_s0;
		b_c3 = -b_s1;
		c2sq = sx64(b_c2) * sx64(b_c2);
		four = sx64(qabs(b_c3)) << (FRAC_BITS + 2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yn_s2[0] <= sat65(65'(dotr(a_s1[DIV_LAT-1].up, a_quo[0], a_s1[DIV_LAT-1].ap, b_s0,
				FRAC_BITS)) - 65'(a_s1[DIV_LAT-1].rb0));
			yn_s2[1] <= sat65(65'(dotr(a_s1[DIV_LAT-1].vp, a_quo[0], a_s1[DIV_LAT-1].cp, b_s0,
				FRAC_BITS)) - 65'(a_s1[DIV_LAT-1].rc0));
			yn_s2[2] <= sat65(65'(dotr(a_s1[DIV_LAT-1].up, a_quo[1], a_s1[DIV_LAT-1].ap, b_s1,
				FRAC_BITS)) - 65'(a_s1[DIV_LAT-1].rb1));
			yn_s2[3] <= sat65(65'(dotr(a_s1[DIV_LAT-1].vp, a_quo[1], a_s1[DIV_LAT-1].cp, b_s1,
				FRAC_BITS)) - 65'(a_s1[DIV_LAT-1].rc1));
			t2_s2[0] <= a_quo[0];
			t2_s2[1] <= a_quo[1];
			c2_s2    <= b_c2;
			c3_s2    <= b_c3;
			wp_s2    <= a_s1[DIV_LAT-1].wp;
			disc_s2  <= (b_c3 <= 0) ? c2sq + four : c2sq - four;
			// positive c3 with c2^2 < 4*c3: no real root
			fail_s2  <= a_s1[DIV_LAT-1].bad || ((b_c3 > 0) && (c2sq < four));
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_dc
		utpps_div u_div (
			.clk (clk),
			.en  (en),
			.num (sx64(yn_s2[i]) <<< FRAC_BITS),
			.den (sx64(wp_s2)),
			.quo (c_quo[i])
		);
	end

	utpps_isqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.din  (disc_s2),
		.root (sq)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3[0].t20  <= t2_s2[0];
			c_s3[0].t21  <= t2_s2[1];
			c_s3[0].c2   <= c2_s2;
			c_s3[0].c3   <= c3_s2;
			c_s3[0].fail <= fail_s2;
			for (int i = 1; i < DIV_LAT; i++)
				c_s3[i] <= c_s3[i-1];
		end
	end

	always_comb begin
		ec2 = {{3{c_s3[DIV_LAT-1].c2[31]}}, c_s3[DIV_LAT-1].c2};
		esq = {2'b00, sq};
		sm  = (c_s3[DIV_LAT-1].c2 > 0) ? -ec2 - esq : -ec2 + esq;
		// halve toward zero
		smj = sm[34] ? sm + 35'sd1 : sm;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s4.y00  <= c_quo[0];
			e_s4.y01  <= c_quo[1];
			e_s4.y02  <= c_s3[DIV_LAT-1].t20;
			e_s4.y10  <= c_quo[2];
			e_s4.y11  <= c_quo[3];
			e_s4.y12  <= c_s3[DIV_LAT-1].t21;
			e_s4.m    <= smj[34:1];
			e_s4.mz   <= (smj[34:1] == '0);
			e_s4.fail <= c_s3[DIV_LAT-1].fail;
			c3_s4     <= c_s3[DIV_LAT-1].c3;
		end
	end

	assign e_num = sx64(c3_s4) <<< FRAC_BITS;

	utpps_div u_dive (
		.clk (clk),
		.en  (en),
		.num (e_num),
		.den ({{30{e_s4.m[33]}}, e_s4.m}),
		.quo (e_quo)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			e_s5[0] <= e_s4;
			for (int i = 1; i < DIV_LAT; i++)
				e_s5[i] <= e_s5[i-1];
		end
	end

	always_comb begin
		mext     = {{31{e_s5[DIV_LAT-1].m[33]}}, e_s5[DIV_LAT-1].m};
		rq[0]    = e_s5[DIV_LAT-1].mz ? '0 : e_quo;
		rq[1]    = sat65(mext);
		yr[0][0] = e_s5[DIV_LAT-1].y00;
		yr[0][1] = e_s5[DIV_LAT-1].y01;
		yr[0][2] = e_s5[DIV_LAT-1].y02;
		yr[1][0] = e_s5[DIV_LAT-1].y10;
		yr[1][1] = e_s5[DIV_LAT-1].y11;
		yr[1][2] = e_s5[DIV_LAT-1].y12;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				den_s6[k]    <= (64'sd1 <<< FRAC_BITS)
					+ ((sx64(rq[k]) * sx64(rq[k])) >>> FRAC_BITS);
				num_s6[k][0] <= (64'sd1 <<< (2 * FRAC_BITS)) - sx64(rq[k]) * sx64(rq[k]);
				num_s6[k][1] <= sx64(rq[k]) <<< (FRAC_BITS + 1);
				for (int i = 0; i < 3; i++)
					num_s6[k][2+i] <= sx64(yr[0][i]) * sx64(rq[k])
						+ (sx64(yr[1][i]) <<< FRAC_BITS);
			end
			fail_s6 <= e_s5[DIV_LAT-1].fail;
		end
	end

	for (genvar k = 0; k < 2; k++) begin : g_root
		for (genvar i = 0; i < 5; i++) begin : g_dg
			utpps_div u_div (
				.clk (clk),
				.en  (en),
				.num (num_s6[k][i]),
				.den (den_s6[k]),
				.quo (g_quo[k][i])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s7[0] <= fail_s6;
			for (int i = 1; i < DIV_LAT; i++)
				g_s7[i] <= g_s7[i-1];
		end
	end

	always_comb begin
		out_item.ok    = !g_s7[DIV_LAT-1];
		out_item.r0.cs = g_quo[0][0];
		out_item.r0.sn = g_quo[0][1];
		out_item.r0.tx = g_quo[0][2];
		out_item.r0.ty = g_quo[0][3];
		out_item.r0.tz = g_quo[0][4];
		out_item.r1.cs = g_quo[1][0];
		out_item.r1.sn = g_quo[1][1];
		out_item.r1.tx = g_quo[1][2];
		out_item.r1.ty = g_quo[1][3];
		out_item.r1.tz = g_quo[1][4];
		if (g_s7[DIV_LAT-1]) begin
			out_item.r0 = '0;
			out_item.r1 = '0;
		end
	end

endmodule

// File: hdl/upright_two_point_pose_solver_core.sv
// Upright two-point absolute pose: rotation about the vertical axis plus
// translation from two bearings and two world points, signed Q format with
// FRAC_BITS fraction bits. One problem is taken per clock while full is low;
// a problem gives two results (one per root of the quadratic) or one result
// with valid_res=0 when the system is singular or has no real root. A request
// passes the front end, a queue, the back end (four 32-stage pipelined
// dividers in series, the 32-stage square root running beside the second of
// them, and three single stages) and the result queue; output stalls hold it
// back. Results leave one per clock while pop is high, and a two-root problem
// takes two pops; a four-entry queue sits between front and back end and
// another before the result port.
module upright_two_point_pose_solver_core import utpps_pkg::*; #(
	parameter int FRAC_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  q_t   bearing0_x,
	input  q_t   bearing0_y,
	input  q_t   bearing0_w,
	input  q_t   bearing1_x,
	input  q_t   bearing1_y,
	input  q_t   bearing1_w,
	input  q_t   point0_x,
	input  q_t   point0_y,
	input  q_t   point0_z,
	input  q_t   point1_x,
	input  q_t   point1_y,
	input  q_t   point1_z,
	output logic empty,
	input  logic pop,
	output q_t   rot_cos,
	output q_t   rot_sin,
	output q_t   trans_x,
	output q_t   trans_y,
	output q_t   trans_z,
	output logic valid_res,
	output logic last
);

	logic f_ready, f_valid;
	mid_t f_item;
	logic m_full, m_empty;
	logic [$bits(mid_t)-1:0] m_dout;
	logic b_ready, b_valid;
	res_t b_item;
	logic o_full, o_empty, o_pop;
	logic [$bits(res_t)-1:0] o_dout;
	res_t head;
	pose_t cur;
	logic sel_q;

	assign full = !f_ready;

	utpps_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (push),
		.in_ready   (f_ready),
		.bearing0_x (bearing0_x),
		.bearing0_y (bearing0_y),
		.bearing0_w (bearing0_w),
		.bearing1_x (bearing1_x),
		.bearing1_y (bearing1_y),
		.bearing1_w (bearing1_w),
		.point0_x   (point0_x),
		.point0_y   (point0_y),
		.point0_z   (point0_z),
		.point1_x   (point1_x),
		.point1_y   (point1_y),
		.point1_z   (point1_z),
		.out_valid  (f_valid),
		.out_ready  (!m_full),
		.out_item   (f_item)
	);

	utpps_fifo #(.W($bits(mid_t)), .DEPTH(4)) u_midq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.din    (f_item),
		.full   (m_full),
		.pop    (b_ready),
		.dout   (m_dout),
		.empty  (m_empty)
	);

	utpps_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!m_empty),
		.in_ready  (b_ready),
		.in_item   (mid_t'(m_dout)),
		.out_valid (b_valid),
		.out_ready (!o_full),
		.out_item  (b_item)
	);

	utpps_fifo #(.W($bits(res_t)), .DEPTH(4)) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_valid),
		.din    (b_item),
		.full   (o_full),
		.pop    (o_pop),
		.dout   (o_dout),
		.empty  (o_empty)
	);

	assign head  = res_t'(o_dout);
	assign empty = o_empty;
	assign o_pop = pop && !o_empty && (!head.ok || sel_q);
	assign cur   = sel_q ? head.r1 : head.r0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sel_q <= 1'b0;
		else if (pop && !o_empty)
			sel_q <= head.ok && !sel_q;
	end

	assign rot_cos   = cur.cs;
	assign rot_sin   = cur.sn;
	assign trans_x   = cur.tx;
	assign trans_y   = cur.ty;
	assign trans_z   = cur.tz;
	assign valid_res = head.ok;
	assign last      = !head.ok || sel_q;

	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !valid_res |-> last)
		else $error("result without pose not marked last");

	a_second_stays: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !last |=> !empty)
		else $error("second root lost after first pop");

	a_second_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !last |=> last && valid_res)
		else $error("result after first root not final");

endmodule

// File: test/tb_upright_two_point_pose_solver_core.sv
module tb_upright_two_point_pose_solver_core import utpps_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 20;
	localparam int WATCHDOG = 20000;
	localparam int DRAIN = 400;
	localparam longint SMAX = 64'sd2147483647;

	typedef struct {
		q_t f[12];
	} problem_t;

	typedef struct {
		q_t   cs;
		q_t   sn;
		q_t   tx;
		q_t   ty;
		q_t   tz;
		logic ok;
		logic lst;
	} pose_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic pop = 0;
	logic full, empty, valid_res, last;
	q_t   fld[12];
	q_t   rot_cos, rot_sin, trans_x, trans_y, trans_z;

	problem_t  pending_problems[$];
	pose_res_t expected_poses[$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	bit        stim_done = 0;
	int        push_gap = 0;
	int        pop_gap = 0;

	always #1 clk = ~clk;

	upright_two_point_pose_solver_core #(.FRAC_BITS(FB)) i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.bearing0_x(fld[0]), .bearing0_y(fld[1]), .bearing0_w(fld[2]),
		.bearing1_x(fld[3]), .bearing1_y(fld[4]), .bearing1_w(fld[5]),
		.point0_x(fld[6]), .point0_y(fld[7]), .point0_z(fld[8]),
		.point1_x(fld[9]), .point1_y(fld[10]), .point1_z(fld[11]),
		.empty(empty), .pop(pop),
		.rot_cos(rot_cos), .rot_sin(rot_sin), .trans_x(trans_x),
		.trans_y(trans_y), .trans_z(trans_z), .valid_res(valid_res), .last(last)
	);

	function automatic longint clamp(longint v);
		return v > SMAX ? SMAX : (v < -SMAX ? -SMAX : v);
	endfunction

	// round half toward +inf via arithmetic shift (floor)
	function automatic longint rnd_q(longint p);
		return clamp((p + (64'sd1 <<< (FB - 1))) >>> FB);
	endfunction

	function automatic longint mulq(longint a, longint b);
		return rnd_q(a * b);
	endfunction

	function automatic longint dotq(longint a, longint b, longint c, longint d);
		return rnd_q(a * b + c * d);
	endfunction

	function automatic longint divq(longint n, longint d);
		return clamp((n * (64'sd1 <<< FB)) / d);
	endfunction

	function automatic longint isqrt64(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic pose_res_t no_pose();
		pose_res_t r;
		r = '{default: '0};
		r.lst = 1;
		return r;
	endfunction

	task automatic predict_poses(problem_t pb);
		longint u[2], v[2], w[2], px[2], py[2], pz[2], a[2], c[2];
		longint rb[2][2], rc[2][2], y[2][3], s[2], root[2], vals[5];
		longint pp, qq_m, rr, ss, det, wp, c2, c3, sq, sm, m, one;
		longint unsigned c2sq, four, disc;
		int p;
		pose_res_t r;
		one = 64'sd1 <<< FB;
		for (int i = 0; i < 2; i++) begin
			u[i] = clamp(longint'(pb.f[3*i]));
			v[i] = clamp(longint'(pb.f[3*i+1]));
			w[i] = clamp(longint'(pb.f[3*i+2]));
			px[i] = clamp(longint'(pb.f[6+3*i]));
			py[i] = clamp(longint'(pb.f[7+3*i]));
			pz[i] = clamp(longint'(pb.f[8+3*i]));
		end
		for (int i = 0; i < 2; i++) begin
			a[i] = dotq(px[i], w[i], pz[i], u[i]);
			c[i] = dotq(py[i], w[i], pz[i], v[i]);
			rb[i][0] = clamp(-2 * mulq(py[i], w[i]));
			rb[i][1] = dotq(px[i], w[i], pz[i], -u[i]);
			rc[i][0] = clamp(2 * mulq(px[i], w[i]));
			rc[i][1] = dotq(py[i], w[i], pz[i], -v[i]);
		end
		pp = dotq(u[0], w[1], u[1], -w[0]);
		qq_m = dotq(a[0], w[1], a[1], -w[0]);
		rr = dotq(v[0], w[1], v[1], -w[0]);
		ss = dotq(c[0], w[1], c[1], -w[0]);
		det = dotq(pp, ss, qq_m, -rr);
		p = ((w[1] < 0 ? -w[1] : w[1]) > (w[0] < 0 ? -w[0] : w[0])) ? 1 : 0;
		wp = w[p];
		if (det == 0 || wp == 0) begin
			expected_poses = {expected_poses, no_pose()};
			return;
		end
		for (int k = 0; k < 2; k++) begin
			longint h, j, t2;
			h = dotq(rb[0][k], w[1], rb[1][k], -w[0]);
			j = dotq(rc[0][k], w[1], rc[1][k], -w[0]);
			t2 = divq(dotq(h, ss, j, -qq_m), det);
			s[k] = divq(dotq(pp, j, rr, -h), det);
			y[k][2] = t2;
			y[k][0] = divq(clamp(dotq(u[p], t2, a[p], s[k]) - rb[p][k]), wp);
			y[k][1] = divq(clamp(dotq(v[p], t2, c[p], s[k]) - rc[p][k]), wp);
		end
		c2 = -s[0];
		c3 = -s[1];
		c2sq = longint'(c2 * c2);
		four = longint'(c3 < 0 ? -c3 : c3) * 4 * one;
		if (c3 <= 0)
			disc = c2sq + four;
		else begin
			if (c2sq < four) begin
				expected_poses = {expected_poses, no_pose()};
				return;
			end
			disc = c2sq - four;
		end
		sq = isqrt64(disc);
		sm = (c2 > 0) ? (-c2 - sq) : (-c2 + sq);
		m = sm / 2;
		root[0] = (m == 0) ? 0 : clamp((c3 * one) / m);
		root[1] = clamp(m);
		for (int k = 0; k < 2; k++) begin
			longint q, qsq, den;
			q = root[k];
			qsq = q * q;
			den = one + (qsq >>> FB);
			vals[0] = clamp((one * one - qsq) / den);
			vals[1] = clamp((2 * q * one) / den);
			for (int i = 0; i < 3; i++)
				vals[2+i] = clamp((y[0][i] * q + y[1][i] * one) / den);
			r.cs = vals[0][31:0];
			r.sn = vals[1][31:0];
			r.tx = vals[2][31:0];
			r.ty = vals[3][31:0];
			r.tz = vals[4][31:0];
			r.ok = 1;
			r.lst = (k == 1);
			expected_poses = {expected_poses, r};
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic q_t rand_q(int mode);
		case (mode)
			0: return $urandom();
			1: return $signed($urandom_range(0, 32'h00800000)) - 32'sh00400000;
			2: return $signed($urandom_range(0, 32'h08000000)) - 32'sh04000000;
			default: return $signed($urandom_range(0, 32'h00040000)) - 32'sh00020000;
		endcase
	endfunction

	// moderate random fields, w kept away from zero
	function automatic problem_t make_geometric();
		problem_t pb;
		int mode;
		mode = $urandom_range(1, 3);
		for (int i = 0; i < 12; i++)
			pb.f[i] = rand_q(mode);
		for (int i = 0; i < 2; i++) begin
			pb.f[3*i+2] = $signed($urandom_range(32'h00080000, 32'h00200000));
			if ($urandom_range(0, 3) == 0)
				pb.f[3*i+2] = -pb.f[3*i+2];
		end
		return pb;
	endfunction

	function automatic problem_t make_noise();
		problem_t pb;
		for (int i = 0; i < 12; i++)
			pb.f[i] = rand_q($urandom_range(0, 3));
		return pb;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_poses(pending_problems.pop_front());
				push_gap <= pick_gap();
			end
			if (!(push && !full) && push) begin
				// hold current request
			end else if (push_gap > 0 && !(push && !full)) begin
				push_gap <= push_gap - 1;
				push <= 0;
			end else if (pending_problems.size() > 0
					&& (push && !full ? pick_gap() == 0 : 1)) begin
				push <= 1;
				for (int i = 0; i < 12; i++)
					fld[i] <= pending_problems[0].f[i];
			end else begin
				push <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				pose_res_t e;
				if (expected_poses.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result cos=%0d sin=%0d", rot_cos, rot_sin);
				end else begin
					e = expected_poses.pop_front();
					if (rot_cos !== e.cs || rot_sin !== e.sn || trans_x !== e.tx ||
							trans_y !== e.ty || trans_z !== e.tz ||
							valid_res !== e.ok || last !== e.lst) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch exp %0d %0d %0d %0d %0d v%0b l%0b",
								" got %0d %0d %0d %0d %0d v%0b l%0b"},
								e.cs, e.sn, e.tx, e.ty, e.tz, e.ok, e.lst,
								rot_cos, rot_sin, trans_x, trans_y, trans_z,
								valid_res, last);
					end
				end
			end
			if (pop_gap > 0) begin
				pop_gap <= pop_gap - 1;
				pop <= 0;
			end else if ($urandom_range(0, 19) == 0) begin
				pop_gap <= pick_gap();
				pop <= 0;
			end else begin
				pop <= 1;
			end
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		problem_t pb;
		q_t edge_vals[6];
		for (int i = 0; i < 12; i++)
			fld[i] = '0;
		edge_vals = '{32'sh80000000, 32'sh7fffffff, 32'sh00000000, 32'sh00100000,
			-32'sh00100000, 32'sh00000001};
		// all-zero problem: singular
		pb.f = '{default: '0};
		pending_problems = {pending_problems, pb};
		// both w zero
		pb = make_geometric();
		pb.f[2] = 0;
		pb.f[5] = 0;
		pending_problems = {pending_problems, pb};
		// equal |w| tie, first row used
		pb = make_geometric();
		pb.f[5] = -pb.f[2];
		pending_problems = {pending_problems, pb};
		// field extremes
		for (int k = 0; k < 6; k++) begin
			pb.f = '{default: edge_vals[k]};
			pending_problems = {pending_problems, pb};
			pb = make_geometric();
			pb.f[k] = edge_vals[k];
			pb.f[11 - k] = edge_vals[5 - k];
			pending_problems = {pending_problems, pb};
		end
		for (int k = 0; k < 6; k++)
			pending_problems = {pending_problems, make_noise()};
		for (int n = 0; n < 1800; n++)
			pending_problems = {pending_problems,
				($urandom_range(0, 9) < 8 ? make_geometric() : make_noise())};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		wait (pending_problems.size() == 0 && !push && expected_poses.size() == 0);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && expected_poses.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG);
		$display("== FAIL ==");
		$finish;
	end
endmodule

// File: upright_two_point_pose_solver_core.f
hdl/utpps_pkg.sv
hdl/utpps_fifo.sv
hdl/utpps_div.sv
hdl/utpps_isqrt.sv
hdl/utpps_front.sv
hdl/utpps_back.sv
hdl/upright_two_point_pose_solver_core.sv
test/tb_upright_two_point_pose_solver_core.sv
